[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the swipe classifier rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SWDL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define SWDL_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[sv/swdl_pkg.sv]
// ----------------------------------------------------------------------------
// swdl_pkg
// types, codes and constants of the swipe direction and length classifier
// ----------------------------------------------------------------------------
package swdl_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;

    localparam logic [15:0] RST_MIN_LENGTH    = 16'd0;
    localparam logic [15:0] RST_SCREEN_WIDTH  = 16'd1920;
    localparam logic [15:0] RST_SCREEN_HEIGHT = 16'd1080;

    // direction codes
    localparam logic [3:0] DIR_NONE       = 4'd0;
    localparam logic [3:0] DIR_UP         = 4'd1;
    localparam logic [3:0] DIR_UP_RIGHT   = 4'd2;
    localparam logic [3:0] DIR_RIGHT      = 4'd3;
    localparam logic [3:0] DIR_DOWN_RIGHT = 4'd4;
    localparam logic [3:0] DIR_DOWN       = 4'd5;
    localparam logic [3:0] DIR_DOWN_LEFT  = 4'd6;
    localparam logic [3:0] DIR_LEFT       = 4'd7;
    localparam logic [3:0] DIR_UP_LEFT    = 4'd8;

    // length class codes
    localparam logic [1:0] LEN_ANY   = 2'd0;
    localparam logic [1:0] LEN_SHORT = 2'd1;
    localparam logic [1:0] LEN_LONG  = 2'd2;
    localparam logic [1:0] LEN_FAR   = 2'd3;

    // reference length selection
    localparam int NUM_REFS = 3;
    localparam logic [1:0] REF_VERT = 2'd0;
    localparam logic [1:0] REF_HORZ = 2'd1;
    localparam logic [1:0] REF_DIAG = 2'd2;

    // tangent scale 10^7 and q16 length factors
    localparam logic [23:0] TAN_SCALE = 24'd10000000;
    localparam longint unsigned FAR_Q16  = 43254;
    localparam longint unsigned LONG_Q16 = 21627;
    localparam logic [30:0] FAR_SQ  = 31'(FAR_Q16 * FAR_Q16);
    localparam logic [30:0] LONG_SQ = 31'(LONG_Q16 * LONG_Q16);

    localparam int D2_W = 33;

    // fifo depth between front and back, a power of two
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] end_x;
        logic [15:0] end_y;
    } t_swipe_in;

    typedef struct packed {
        logic [3:0] direction;
        logic [1:0] length_class;
    } t_swipe_out;

    typedef struct packed {
        logic [3:0]      dir;
        logic [D2_W-1:0] d2;
    } t_q_entry;

    // thresholds derived from the configuration
    typedef struct packed {
        logic                           settling;
        logic [31:0]                    min_len_sq;
        logic [NUM_REFS-1:0][D2_W-1:0]  need_far;
        logic [NUM_REFS-1:0][D2_W-1:0]  need_long;
    } t_lim_bus;

    // round(tan(deg) * 10^7), window clamped to 0..22 degrees
    function automatic logic [23:0] tan_q7(input int deg);
        int d;
        logic [23:0] t;
        d = deg;
        if (d < 0) d = 0;
        if (d > 22) d = 22;
        case (d)
            1:       t = 24'd174551;
            2:       t = 24'd349208;
            3:       t = 24'd524078;
            4:       t = 24'd699268;
            5:       t = 24'd874887;
            6:       t = 24'd1051042;
            7:       t = 24'd1227846;
            8:       t = 24'd1405408;
            9:       t = 24'd1583844;
            10:      t = 24'd1763270;
            11:      t = 24'd1943803;
            12:      t = 24'd2125566;
            13:      t = 24'd2308682;
            14:      t = 24'd2493280;
            15:      t = 24'd2679492;
            16:      t = 24'd2867454;
            17:      t = 24'd3057307;
            18:      t = 24'd3249197;
            19:      t = 24'd3443276;
            20:      t = 24'd3639702;
            21:      t = 24'd3838640;
            22:      t = 24'd4040262;
            default: t = 24'd0;
        endcase
        return t;
    endfunction

endpackage

[sv/swdl_limits.sv]
// ----------------------------------------------------------------------------
// swdl_limits
// configuration registers and the length thresholds derived from them
// ----------------------------------------------------------------------------
module swdl_limits (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [swdl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output swdl_pkg::t_lim_bus            o_lim
);
    import swdl_pkg::*;

    localparam logic [2:0] SETTLE_CYCLES = 3'd5;

    logic [15:0] r_min_length;
    logic [15:0] r_screen_width;
    logic [15:0] r_screen_height;
    logic [2:0]  r_settle;

    logic [31:0] r_ml2;
    logic [31:0] r_w2;
    logic [31:0] r_h2;
    logic [D2_W-1:0] r_ref [NUM_REFS];
    logic [46:0] r_pl_far [NUM_REFS];
    logic [47:0] r_ph_far [NUM_REFS];
    logic [46:0] r_pl_lng [NUM_REFS];
    logic [47:0] r_ph_lng [NUM_REFS];
    logic [63:0] r_p_far [NUM_REFS];
    logic [63:0] r_p_lng [NUM_REFS];
    logic [D2_W-1:0] r_need_far [NUM_REFS];
    logic [D2_W-1:0] r_need_lng [NUM_REFS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length    <= RST_MIN_LENGTH;
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_settle        <= SETTLE_CYCLES;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MIN_LENGTH:    r_min_length    <= i_cfg_data;
                    REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                    REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                    default: ;
                endcase
                r_settle <= SETTLE_CYCLES;
            end else if (r_settle != 3'd0) begin
                r_settle <= r_settle - 3'd1;
            end
        end
    end

    // threshold pipeline: squares, references, partial products, sum, ceiling
    always_ff @(posedge i_clk) begin
        r_ml2 <= 32'(r_min_length) * 32'(r_min_length);
        r_w2  <= 32'(r_screen_width) * 32'(r_screen_width);
        r_h2  <= 32'(r_screen_height) * 32'(r_screen_height);
        r_ref[REF_VERT] <= D2_W'(r_h2);
        r_ref[REF_HORZ] <= D2_W'(r_w2);
        r_ref[REF_DIAG] <= D2_W'(r_w2) + D2_W'(r_h2);
        for (int i = 0; i < NUM_REFS; i++) begin
            r_pl_far[i] <= 47'(r_ref[i][15:0]) * 47'(FAR_SQ);
            r_ph_far[i] <= 48'(r_ref[i][D2_W-1:16]) * 48'(FAR_SQ);
            r_pl_lng[i] <= 47'(r_ref[i][15:0]) * 47'(LONG_SQ);
            r_ph_lng[i] <= 48'(r_ref[i][D2_W-1:16]) * 48'(LONG_SQ);
            r_p_far[i]  <= 64'(r_pl_far[i]) + {r_ph_far[i], 16'd0};
            r_p_lng[i]  <= 64'(r_pl_lng[i]) + {r_ph_lng[i], 16'd0};
            // round up: any fraction below 2^32 needs one more
            r_need_far[i] <= D2_W'(r_p_far[i][63:32]) + D2_W'(|r_p_far[i][31:0]);
            r_need_lng[i] <= D2_W'(r_p_lng[i][63:32]) + D2_W'(|r_p_lng[i][31:0]);
        end
    end

    always_comb begin
        o_lim.settling   = (r_settle != 3'd0);
        o_lim.min_len_sq = r_ml2;
        for (int i = 0; i < NUM_REFS; i++) begin
            o_lim.need_far[i]  = r_need_far[i];
            o_lim.need_long[i] = r_need_lng[i];
        end
    end

endmodule

[sv/swdl_front.sv]
// ----------------------------------------------------------------------------
// swdl_front
// takes swipe words, finds the motion vector and classifies the direction
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swdl_front #(
    parameter int ANGLE_WINDOW_DEG = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  swdl_pkg::t_swipe_in  i_in,
    input  logic [31:0]          i_min_len_sq,
    output logic                 o_push,
    output swdl_pkg::t_q_entry   o_entry,
    output logic [1:0]           o_inflight
);
    import swdl_pkg::*;

    localparam logic [23:0] TAN_W   = tan_q7(ANGLE_WINDOW_DEG);
    localparam logic [23:0] DIAG_LO = 24'(TAN_SCALE + TAN_W);
    localparam logic [23:0] DIAG_HI = 24'(TAN_SCALE - TAN_W);

    logic [16:0] dx;
    logic [16:0] du;

    // stage 1
    logic        r_v1;
    logic [15:0] r_a;
    logic [15:0] r_b;
    logic        r_dx_pos1;
    logic        r_du_pos1;
    logic        r_du_neg1;

    // stage 2
    logic        r_v2;
    logic [31:0] r_aa;
    logic [31:0] r_bb;
    logic [39:0] r_ax_lhs;
    logic [39:0] r_ax_rhs;
    logic [39:0] r_dg_lhs;
    logic [39:0] r_dg_rhs;
    logic        r_b_ge_a;
    logic        r_dx_pos2;
    logic        r_du_pos2;
    logic        r_du_neg2;

    logic [15:0]     lo;
    logic [15:0]     hi;
    logic [D2_W-1:0] d2;
    logic            reach;
    logic            in_axis;
    logic            in_diag;
    logic [3:0]      dir;

    assign dx = {1'b0, i_in.end_x} - {1'b0, i_in.start_x};
    assign du = {1'b0, i_in.start_y} - {1'b0, i_in.end_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= dx[16] ? 16'(-dx) : dx[15:0];
        r_b       <= du[16] ? 16'(-du) : du[15:0];
        r_dx_pos1 <= !dx[16] && (dx != 17'd0);
        r_du_pos1 <= !du[16] && (du != 17'd0);
        r_du_neg1 <= du[16];
    end

    assign lo = (r_b >= r_a) ? r_a : r_b;
    assign hi = (r_b >= r_a) ? r_b : r_a;

    always_ff @(posedge i_clk) begin
        r_aa      <= 32'(r_a) * 32'(r_a);
        r_bb      <= 32'(r_b) * 32'(r_b);
        r_ax_lhs  <= 40'(lo) * 40'(TAN_SCALE);
        r_ax_rhs  <= 40'(hi) * 40'(TAN_W);
        r_dg_lhs  <= 40'(lo) * 40'(DIAG_LO);
        r_dg_rhs  <= 40'(hi) * 40'(DIAG_HI);
        r_b_ge_a  <= (r_b >= r_a);
        r_dx_pos2 <= r_dx_pos1;
        r_du_pos2 <= r_du_pos1;
        r_du_neg2 <= r_du_neg1;
    end

    assign d2      = D2_W'(r_aa) + D2_W'(r_bb);
    assign reach   = (d2 >= D2_W'(i_min_len_sq));
    assign in_axis = (r_ax_lhs <= r_ax_rhs);
    assign in_diag = (r_dg_lhs >= r_dg_rhs);

    // axis window wins over the diagonal one
    always_comb begin
        dir = DIR_NONE;
        if (reach) begin
            if (in_axis) begin
                if (r_b_ge_a) dir = r_du_neg2 ? DIR_DOWN : DIR_UP;
                else          dir = r_dx_pos2 ? DIR_RIGHT : DIR_LEFT;
            end else if (in_diag) begin
                if (r_du_pos2) dir = r_dx_pos2 ? DIR_UP_RIGHT : DIR_UP_LEFT;
                else           dir = r_dx_pos2 ? DIR_DOWN_RIGHT : DIR_DOWN_LEFT;
            end
        end
    end

    assign o_push       = r_v2;
    assign o_entry.dir  = dir;
    assign o_entry.d2   = d2;
    assign o_inflight   = 2'(r_v1) + 2'(r_v2);

    `SWDL_NEVER(a_front_dir_range, i_clk, i_rst_n, o_push && (dir > DIR_UP_LEFT), "front direction code out of range")

endmodule

[sv/swdl_queue.sv]
// ----------------------------------------------------------------------------
// swdl_queue
// short fifo between the classifying front and the length back end
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swdl_queue (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_push,
    input  swdl_pkg::t_q_entry                       i_entry,
    output logic                                     o_valid,
    output swdl_pkg::t_q_entry                       o_entry,
    output logic [$clog2(swdl_pkg::Q_DEPTH+1)-1:0]   o_count
);
    import swdl_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_q_entry      r_mem [Q_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          r_valid;
    t_q_entry      r_entry;
    logic          pop;

    // the back end never stalls: drain whenever there is a word
    assign pop = (r_count != CW'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + AW'(1);
            if (pop)    r_rd_ptr <= r_rd_ptr + AW'(1);
            r_count <= r_count + CW'(i_push) - CW'(pop);
            r_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
        if (pop)    r_entry <= r_mem[r_rd_ptr];
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_count = r_count;

    `SWDL_NEVER(a_queue_overflow, i_clk, i_rst_n, i_push && !pop && (r_count == CW'(Q_DEPTH)), "push into full queue")
    `SWDL_ASSERT(a_queue_read_had_word, i_clk, i_rst_n, r_valid |-> $past(r_count) != CW'(0), "queue read without a stored word")

endmodule

[sv/swdl_back.sv]
// ----------------------------------------------------------------------------
// swdl_back
// length classing against the screen thresholds and the result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swdl_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  swdl_pkg::t_q_entry   i_entry,
    input  swdl_pkg::t_lim_bus   i_lim,
    output logic                 o_valid,
    output swdl_pkg::t_swipe_out o_res
);
    import swdl_pkg::*;

    logic       r_valid;
    t_swipe_out r_res;
    logic [1:0] ref_sel;
    logic       has_dir;
    logic [1:0] cls;

    always_comb begin
        has_dir = 1'b1;
        ref_sel = REF_DIAG;
        case (i_entry.dir) inside
            DIR_UP, DIR_DOWN:    ref_sel = REF_VERT;
            DIR_LEFT, DIR_RIGHT: ref_sel = REF_HORZ;
            DIR_NONE:            has_dir = 1'b0;
            default:             ref_sel = REF_DIAG;
        endcase
    end

    always_comb begin
        if (!has_dir)
            cls = LEN_ANY;
        else if (i_entry.d2 >= i_lim.need_far[ref_sel])
            cls = LEN_FAR;
        else if (i_entry.d2 >= i_lim.need_long[ref_sel])
            cls = LEN_LONG;
        else
            cls = LEN_SHORT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.direction    <= i_entry.dir;
        r_res.length_class <= cls;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    `SWDL_ASSERT(a_back_any_iff_none, i_clk, i_rst_n, r_valid |-> ((r_res.direction == DIR_NONE) == (r_res.length_class == LEN_ANY)), "length class and direction disagree")

endmodule

[sv/swipe_direction_and_length_classifier.sv]
// ----------------------------------------------------------------------------
// swipe_direction_and_length_classifier
// swipe direction and length class from a touch start and end point
// ----------------------------------------------------------------------------
// usage:
//   input: drive start high with a start/end point word on i_in; the word is
//   taken at a clock edge where start is high and busy is low.
//   result: o_valid pulses for one cycle with direction and length class on
//   o_res for each taken word, in input order. the receiver
//   cannot hold results off, so nothing downstream stalls the block.
//   throughput: one word per cycle while busy is low. the front computes the vector,
//   squares and window products over two stages, pushes into a short fifo, and
//   the back end compares against the screen thresholds and registers the result.
//   configuration: write min_length, screen_width, screen_height over the
//   i_cfg_* channel (always ready) while no word is in flight. the thresholds
//   are rebuilt by a 5-stage pipeline, and busy stays high while they rebuild.
//   reset: synchronous, active low; registers go to 0 / 1920 / 1080, the fifo
//   empties, and busy is high after reset while the thresholds build.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swipe_direction_and_length_classifier #(
    parameter int ANGLE_WINDOW_DEG = 15
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  swdl_pkg::t_swipe_in            i_in,
    output logic                           o_valid,
    output swdl_pkg::t_swipe_out           o_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [swdl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import swdl_pkg::*;

    localparam int CW      = $clog2(Q_DEPTH + 1);
    localparam int LATENCY = 5;

    t_lim_bus      lim;
    logic          accept;
    logic          push;
    t_q_entry      push_entry;
    logic [1:0]    inflight;
    logic          q_valid;
    t_q_entry      q_entry;
    logic [CW-1:0] q_count;
    logic [CW:0]   fill;

    // reserve room for every word still in the front stages
    assign fill        = (CW+1)'(q_count) + (CW+1)'(inflight);
    assign busy        = lim.settling || (fill >= (CW+1)'(Q_DEPTH));
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    swdl_limits u_limits (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_lim       (lim)
    );

    swdl_front #(
        .ANGLE_WINDOW_DEG (ANGLE_WINDOW_DEG)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in         (i_in),
        .i_min_len_sq (lim.min_len_sq),
        .o_push       (push),
        .o_entry      (push_entry),
        .o_inflight   (inflight)
    );

    swdl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .o_count (q_count)
    );

    swdl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .i_lim   (lim),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    `SWDL_ASSERT(a_top_result_latency, i_clk, i_rst_n, accept |-> ##LATENCY o_valid, "taken word gave no result on time")

endmodule

[tb/sv/tb_swipe_direction_and_length_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_swipe_direction_and_length_classifier
// self-checking bench for the swipe direction and length classifier
// ----------------------------------------------------------------------------
// Touch words are pushed into a send queue phase by phase. Later phases first
// set the screen registers. A clocked driver sends the queued words in
// bursts with random gaps. Each accepted word is classified by a local
// integer model of the block, and the result is queued. A clocked monitor
// compares every result strobe with the oldest queued result. The phases use
// the reset setting, a min length boundary setting, the extreme register values,
// a zero-size screen and random screens. Directed words cover the axes, the
// diagonals, the window boundaries and zero-length swipes. Random words aim at
// the window and length thresholds, and some are fully random.
// ----------------------------------------------------------------------------
module tb_swipe_direction_and_length_classifier;
    import swdl_pkg::*;

    localparam int              WINDOW_DEG       = 15;
    // tan(15 deg) scaled by 10^7, must follow WINDOW_DEG
    localparam longint unsigned WIN_TAN          = 64'd2679492;
    localparam longint unsigned TAN_ONE          = 64'd10000000;
    localparam longint unsigned FAR_FACTOR       = 64'd43254;
    localparam longint unsigned LONG_FACTOR      = 64'd21627;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
    localparam int              RANDOM_PER_PHASE = 125;
    localparam int              TAIL_CYCLES      = 16;
    localparam int              CYCLE_LIMIT      = 200000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_swipe_in            i_in        = '0;
    logic                 o_valid;
    t_swipe_out           o_res;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data  = '0;

    // local copy of the screen registers
    logic [15:0] cfg_min_len = RST_MIN_LENGTH;
    logic [15:0] cfg_width   = RST_SCREEN_WIDTH;
    logic [15:0] cfg_height  = RST_SCREEN_HEIGHT;

    t_swipe_in  swipes_to_send[$];
    t_swipe_out gestures_due[$];

    int n_swipes_sent   = 0;
    int n_checked       = 0;
    int n_with_dir      = 0;
    int n_mismatches    = 0;
    int n_cfg_writes    = 0;
    int n_settings      = 0;
    int n_cycles        = 0;
    int gap_left        = 0;
    int burst_left      = 1;

    always #10 i_clk = ~i_clk;

    swipe_direction_and_length_classifier #(
        .ANGLE_WINDOW_DEG(WINDOW_DEG)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // squared length needed to reach factor * sqrt(ref2), factor in q16
    function automatic longint unsigned reach_sq(input longint unsigned factor,
                                                 input longint unsigned ref2);
        longint unsigned p;
        p = factor * factor * ref2;
        return (p >> 32) + ((p[31:0] != 32'd0) ? 64'd1 : 64'd0);
    endfunction

    function automatic t_swipe_out classify_swipe(input t_swipe_in pt);
        int              dx;
        int              du;
        longint unsigned a, b, d2, lo, hi, ml, wd, ht, r2;
        t_swipe_out      g;
        dx = int'(pt.end_x) - int'(pt.start_x);
        du = int'(pt.start_y) - int'(pt.end_y);
        a  = (dx < 0) ? -dx : dx;
        b  = (du < 0) ? -du : du;
        d2 = a * a + b * b;
        ml = cfg_min_len;
        wd = cfg_width;
        ht = cfg_height;
        g.direction    = DIR_NONE;
        g.length_class = LEN_ANY;
        if (d2 >= ml * ml) begin
            // axis window first, then diagonal window
            if (b >= a) begin
                if (a * TAN_ONE <= b * WIN_TAN)
                    g.direction = (du < 0) ? DIR_DOWN : DIR_UP;
            end else if (b * TAN_ONE <= a * WIN_TAN) begin
                g.direction = (dx > 0) ? DIR_RIGHT : DIR_LEFT;
            end
            if (g.direction == DIR_NONE) begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                if (lo * (TAN_ONE + WIN_TAN) >= hi * (TAN_ONE - WIN_TAN)) begin
                    if (du > 0)
                        g.direction = (dx > 0) ? DIR_UP_RIGHT : DIR_UP_LEFT;
                    else
                        g.direction = (dx > 0) ? DIR_DOWN_RIGHT : DIR_DOWN_LEFT;
                end
            end
        end
        case (g.direction)
            DIR_UP, DIR_DOWN:    r2 = ht * ht;
            DIR_LEFT, DIR_RIGHT: r2 = wd * wd;
            default:             r2 = wd * wd + ht * ht;
        endcase
        if (g.direction != DIR_NONE) begin
            if (d2 >= reach_sq(FAR_FACTOR, r2))
                g.length_class = LEN_FAR;
            else if (d2 >= reach_sq(LONG_FACTOR, r2))
                g.length_class = LEN_LONG;
            else
                g.length_class = LEN_SHORT;
        end
        return g;
    endfunction

    // random swipe, mostly aimed at the window edges and the screen scale
    function automatic t_swipe_in rand_swipe();
        int        span, hi, lo, ax, ay, dx, dy, sx, sy;
        t_swipe_in s;
        if ($urandom_range(0, 9) < 2) begin
            s = {$urandom, $urandom};
            return s;
        end
        case ($urandom_range(0, 3))
            0:       span = $urandom_range(0, 24);
            1, 2:    span = 2 * ((cfg_width > cfg_height) ? cfg_width : cfg_height);
            default: span = 65535;
        endcase
        if (span > 65535)
            span = 65535;
        hi = $urandom_range(0, span);
        case ($urandom_range(0, 4))
            0:       lo = 0;
            1:       lo = hi * $urandom_range(2600, 2760) / 10000;
            2:       lo = hi * $urandom_range(5700, 5850) / 10000;
            3:       lo = hi;
            default: lo = $urandom_range(0, hi);
        endcase
        if ($urandom_range(0, 1)) begin
            ax = hi;
            ay = lo;
        end else begin
            ax = lo;
            ay = hi;
        end
        dx = $urandom_range(0, 1) ? ax : -ax;
        dy = $urandom_range(0, 1) ? ay : -ay;
        sx = (dx >= 0) ? $urandom_range(0, 65535 - dx) : $urandom_range(-dx, 65535);
        sy = (dy >= 0) ? $urandom_range(0, 65535 - dy) : $urandom_range(-dy, 65535);
        s.start_x = sx[15:0];
        s.start_y = sy[15:0];
        s.end_x   = 16'(sx + dx);
        s.end_y   = 16'(sy + dy);
        return s;
    endfunction

    task automatic add_swipe(input int sx, input int sy, input int ex, input int ey);
        t_swipe_in s;
        s.start_x = sx[15:0];
        s.start_y = sy[15:0];
        s.end_x   = ex[15:0];
        s.end_y   = ey[15:0];
        swipes_to_send.push_back(s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_LENGTH:    cfg_min_len = val;
            REG_SCREEN_WIDTH:  cfg_width   = val;
            REG_SCREEN_HEIGHT: cfg_height  = val;
            default:           ;
        endcase
        n_cfg_writes++;
    endtask

    task automatic set_screen(input logic [15:0] min_len, input logic [15:0] wd,
                              input logic [15:0] ht);
        write_reg(REG_MIN_LENGTH, min_len);
        write_reg(REG_SCREEN_WIDTH, wd);
        write_reg(REG_SCREEN_HEIGHT, ht);
        if ($urandom_range(0, 1))
            write_reg(REG_SPARE, 16'($urandom));
        @(negedge i_clk);
        n_settings++;
    endtask

    task automatic send_random(input int count);
        repeat (count)
            swipes_to_send.push_back(rand_swipe());
    endtask

    // idle check on the falling edge, after all rising-edge updates settle
    task automatic drain();
        while (swipes_to_send.size() != 0 || start || gestures_due.size() != 0)
            @(negedge i_clk);
    endtask

    // driver: bursts of words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                gestures_due.push_back(classify_swipe(i_in));
                n_swipes_sent++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (swipes_to_send.size() > 0) begin
                    start <= 1'b1;
                    i_in  <= swipes_to_send.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe is one result word
    always @(posedge i_clk) begin
        t_swipe_out want;
        if (i_rst_n && o_valid) begin
            if (gestures_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, got dir %0d class %0d",
                         $time, o_res.direction, o_res.length_class);
                n_mismatches++;
            end else begin
                want = gestures_due.pop_front();
                n_checked++;
                if (want.direction != DIR_NONE)
                    n_with_dir++;
                if (o_res.direction !== want.direction) begin
                    $display("%0t: direction mismatch: expected %0d, got %0d",
                             $time, want.direction, o_res.direction);
                    n_mismatches++;
                end
                if (o_res.length_class !== want.length_class) begin
                    $display("%0t: length class mismatch: expected %0d, got %0d",
                             $time, want.length_class, o_res.length_class);
                    n_mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, gestures_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: extremes, axes, diagonals, window boundaries
        n_settings++;
        add_swipe(100, 100, 100, 100);
        add_swipe(0, 0, 0, 0);
        add_swipe(65535, 65535, 65535, 65535);
        add_swipe(0, 0, 65535, 65535);
        add_swipe(65535, 65535, 0, 0);
        add_swipe(0, 65535, 65535, 0);
        add_swipe(65535, 0, 0, 65535);
        add_swipe(500, 1000, 500, 0);
        add_swipe(500, 0, 500, 400);
        add_swipe(0, 300, 65535, 300);
        add_swipe(1000, 300, 900, 300);
        add_swipe(20000, 20000, 22679, 10000);     // just inside the axis window
        add_swipe(20000, 20000, 22680, 10000);     // just outside, in the gap
        add_swipe(20000, 20000, 25774, 10000);     // just inside the diagonal window
        add_swipe(20000, 20000, 25773, 10000);     // just outside the diagonal
        add_swipe(30000, 20000, 20000, 22679);
        add_swipe(20000, 20000, 30000, 25774);
        add_swipe(7, 7, 8, 7);
        add_swipe(7, 7, 7, 8);
        send_random(RANDOM_PER_PHASE);
        drain();

        // min length boundary
        set_screen(16'd100, 16'd1080, 16'd1920);
        add_swipe(1000, 1000, 1100, 1000);
        add_swipe(1000, 1000, 1099, 1000);
        add_swipe(1000, 1000, 1060, 920);
        add_swipe(1000, 1000, 1060, 921);
        send_random(RANDOM_PER_PHASE);
        drain();

        set_screen(16'd0, 16'd65535, 16'd65535);
        send_random(RANDOM_PER_PHASE);
        drain();

        set_screen(16'd65535, 16'd1, 16'd1);
        add_swipe(0, 0, 65535, 0);
        add_swipe(0, 0, 65535, 65535);
        send_random(RANDOM_PER_PHASE);
        drain();

        // zero-size screen: every direction classes as far
        set_screen(16'd0, 16'd0, 16'd0);
        add_swipe(40, 40, 40, 40);
        send_random(RANDOM_PER_PHASE);
        drain();

        for (k = 0; k < 5; k++) begin
            set_screen(16'($urandom_range(0, 400)), 16'($urandom_range(1, 4000)),
                       16'($urandom_range(1, 4000)));
            send_random(RANDOM_PER_PHASE);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("checked %0d of %0d swipes over %0d screen settings (%0d register writes)",
                 n_checked, n_swipes_sent, n_settings, n_cfg_writes);
        $display("%0d swipes had a direction, %0d had none",
                 n_with_dir, n_checked - n_with_dir);
        if (n_mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
